// ===== hdl/gha_pkg.sv =====
// Shared types, opcodes, status codes and default sizes for the handle allocator.
// No dependencies; every other file of the block imports this package.
package gha_pkg;

	localparam int SLOT_COUNT_DEF = 1024;
	localparam int SIG_BITS_DEF   = 32;
	localparam int LOC_BITS_DEF   = 32;

	localparam int FIELD_W   = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int LIVE_W    = 11;
	localparam int S_TDATA_W = 4 * FIELD_W;
	localparam int M_TDATA_W = 144;

	localparam logic [FIELD_W-1:0] ALL_ONES = '1;

	localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_LOC = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_SIG = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

	localparam logic [STATUS_W-1:0] STS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STS_BAD  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // capture input transfer, read slot memories
		logic go;      // commit operation, load result register
		logic clear;   // post-reset sweep of all memories
	} gha_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
	} gha_sts_t;

endpackage

// ===== hdl/gha_ctrl.sv =====
// Controller state machine for the handle allocator: clearing sweep, accept, commit.
// Depends on gha_pkg; drives the datapath through gha_cmd_t.
module gha_ctrl
	import gha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output gha_cmd_t cmd,
	input  gha_sts_t sts
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;

	assign s_tready   = (state_q == ST_IDLE);
	assign cmd.accept = s_tready && s_tvalid;
	assign cmd.clear  = (state_q == ST_CLEAR);
	// commit only when the result register is free or being drained
	assign cmd.go     = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
	assign m_tvalid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (cmd.go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_go_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |=> m_tvalid)
		else $error("result not presented after commit");

	a_no_commit_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.go)
		else $error("commit overwrote a pending result");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (!s_tready && !cmd.clear))
		else $error("second transfer taken before commit");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !s_tready)
		else $error("transfer accepted during clearing sweep");

endmodule

// ===== hdl/gha_datapath.sv =====
// Datapath of the handle allocator: free-index FIFO, slot memories, counters, result register.
// Depends on gha_pkg; sequenced by gha_ctrl through gha_cmd_t / gha_sts_t.
module gha_datapath
	import gha_pkg::*;
#(
	parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
	parameter int SIGNATURE_BITS = SIG_BITS_DEF,
	parameter int LOCATION_BITS  = LOC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gha_cmd_t            cmd,
	output gha_sts_t            sts,
	input  logic [OP_W-1:0]     opcode,
	input  logic [FIELD_W-1:0]  handle_index,
	input  logic [FIELD_W-1:0]  handle_generation,
	input  logic [FIELD_W-1:0]  signature_in,
	input  logic [FIELD_W-1:0]  location_in,
	output logic [STATUS_W-1:0] status,
	output logic [FIELD_W-1:0]  new_index,
	output logic [FIELD_W-1:0]  new_generation,
	output logic                alive_flag,
	output logic [FIELD_W-1:0]  location_out,
	output logic [FIELD_W-1:0]  signature_out,
	output logic [LIVE_W-1:0]   live_count
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int FILL_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [FILL_W-1:0]  FILL_MAX = FILL_W'(SLOT_COUNT);
	localparam logic [FIELD_W-1:0] SLOT_LIM = FIELD_W'(SLOT_COUNT);

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	// memories
	logic [IDX_W-1:0]          fifo_mem [SLOT_COUNT];
	logic [FIELD_W-1:0]        gen_mem  [SLOT_COUNT];
	logic [SIGNATURE_BITS-1:0] sig_mem  [SLOT_COUNT];
	logic [LOCATION_BITS-1:0]  loc_mem  [SLOT_COUNT];

	// control state
	logic [IDX_W-1:0]  head_q, tail_q, clr_q;
	logic [FILL_W-1:0] fill_q;
	logic [LIVE_W-1:0] live_q;

	// captured operation and read data
	logic [OP_W-1:0]           op_q;
	logic [FIELD_W-1:0]        idx_q, gen_in_q, sig_in_q, loc_in_q;
	logic [IDX_W-1:0]          slot_q, fifo_rd_q;
	logic [FIELD_W-1:0]        gen_rd_q;
	logic [SIGNATURE_BITS-1:0] sig_rd_q;
	logic [LOCATION_BITS-1:0]  loc_rd_q;

	logic [IDX_W-1:0] rd_slot;
	assign rd_slot = (opcode == OP_CREATE) ? fifo_rd_q : handle_index[IDX_W-1:0];

	assign sts.clr_last = (clr_q == LAST_IDX);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= opcode;
			idx_q    <= handle_index;
			gen_in_q <= handle_generation;
			sig_in_q <= signature_in;
			loc_in_q <= location_in;
			slot_q   <= rd_slot;
		end
	end

	// operation decode
	logic                      invalid, in_range, gen_match;
	logic                      pop, push, x_gen_we, x_sig_we, x_loc_we;
	logic [SIGNATURE_BITS-1:0] x_sig_wd, sig_wr;
	logic [LOCATION_BITS-1:0]  x_loc_wd, loc_wr;
	logic [63:0]               sig_rd_ext, loc_rd_ext;
	logic [STATUS_W-1:0]       status_n;
	logic [FIELD_W-1:0]        nidx_n, ngen_n, lo_n, so_n;
	logic                      alive_n;
	logic [LIVE_W-1:0]         live_n;

	assign invalid    = (idx_q == ALL_ONES) && (gen_in_q == ALL_ONES);
	assign in_range   = (idx_q < SLOT_LIM);
	assign gen_match  = (gen_rd_q == gen_in_q);
	assign sig_wr     = SIGNATURE_BITS'({32'd0, sig_in_q});
	assign loc_wr     = LOCATION_BITS'({32'd0, loc_in_q});
	assign sig_rd_ext = 64'(sig_rd_q);
	assign loc_rd_ext = 64'(loc_rd_q);

	always_comb begin
		pop      = 1'b0;
		push     = 1'b0;
		x_gen_we = 1'b0;
		x_sig_we = 1'b0;
		x_loc_we = 1'b0;
		x_sig_wd = '0;
		x_loc_wd = '0;
		status_n = STS_BAD;
		nidx_n   = '0;
		ngen_n   = '0;
		lo_n     = '0;
		so_n     = '0;
		alive_n  = 1'b0;
		live_n   = live_q;
		case (op_q)
			OP_CREATE: begin
				if (fill_q == '0) begin
					status_n = STS_FULL;
					nidx_n   = ALL_ONES;
					ngen_n   = ALL_ONES;
				end else begin
					pop      = 1'b1;
					x_sig_we = 1'b1;
					x_sig_wd = sig_wr;
					live_n   = live_q + LIVE_W'(1);
					status_n = STS_DONE;
					nidx_n   = FIELD_W'(slot_q);
					ngen_n   = gen_rd_q;
				end
			end
			OP_DESTROY: begin
				if (!invalid && in_range && gen_match) begin
					x_gen_we = 1'b1;
					x_sig_we = 1'b1;
					x_loc_we = 1'b1;
					// destroying an already free slot must not overfill the list
					push     = (fill_q < FILL_MAX);
					if (live_q != '0) live_n = live_q - LIVE_W'(1);
					status_n = STS_DONE;
				end
			end
			OP_SET_LOC: begin
				if (in_range) begin
					x_loc_we = 1'b1;
					x_loc_wd = loc_wr;
					status_n = STS_DONE;
				end
			end
			OP_SET_SIG: begin
				if (in_range) begin
					x_sig_we = 1'b1;
					x_sig_wd = sig_wr;
					status_n = STS_DONE;
				end
			end
			OP_QUERY: begin
				if (!invalid && in_range) begin
					lo_n     = loc_rd_ext[FIELD_W-1:0];
					so_n     = sig_rd_ext[FIELD_W-1:0];
					alive_n  = gen_match && (loc_rd_q != '0);
					status_n = gen_match ? STS_DONE : STS_BAD;
				end
			end
			default: ;
		endcase
	end

	// memory write ports, shared with the clearing sweep
	logic                      gen_we, sig_we, loc_we, fifo_we;
	logic [IDX_W-1:0]          slot_waddr, fifo_waddr, fifo_wd, fifo_raddr;
	logic [FIELD_W-1:0]        gen_wd;
	logic [SIGNATURE_BITS-1:0] sig_wd;
	logic [LOCATION_BITS-1:0]  loc_wd;

	assign gen_we     = cmd.clear || (cmd.go && x_gen_we);
	assign sig_we     = cmd.clear || (cmd.go && x_sig_we);
	assign loc_we     = cmd.clear || (cmd.go && x_loc_we);
	assign slot_waddr = cmd.clear ? clr_q : slot_q;
	assign gen_wd     = cmd.clear ? '0 : gen_rd_q + FIELD_W'(1);
	assign sig_wd     = cmd.clear ? '0 : x_sig_wd;
	assign loc_wd     = cmd.clear ? '0 : x_loc_wd;

	assign fifo_we    = cmd.clear || (cmd.go && push);
	assign fifo_waddr = cmd.clear ? clr_q : tail_q;
	assign fifo_wd    = cmd.clear ? clr_q : idx_q[IDX_W-1:0];
	// head entry is fetched ahead so a create can address the slots in its accept cycle
	assign fifo_raddr = (cmd.go && pop) ? wrap_next(head_q) : head_q;

	always_ff @(posedge clk) begin
		if (gen_we) gen_mem[slot_waddr] <= gen_wd;
		if (cmd.accept) gen_rd_q <= gen_mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (sig_we) sig_mem[slot_waddr] <= sig_wd;
		if (cmd.accept) sig_rd_q <= sig_mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (loc_we) loc_mem[slot_waddr] <= loc_wd;
		if (cmd.accept) loc_rd_q <= loc_mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wd;
		if (fifo_we && (fifo_waddr == fifo_raddr)) begin
			fifo_rd_q <= fifo_wd;
		end else begin
			fifo_rd_q <= fifo_mem[fifo_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			clr_q  <= '0;
			fill_q <= FILL_MAX;
			live_q <= '0;
		end else begin
			if (cmd.clear) clr_q <= wrap_next(clr_q);
			if (cmd.go) begin
				live_q <= live_n;
				if (pop) begin
					head_q <= wrap_next(head_q);
					fill_q <= fill_q - FILL_W'(1);
				end
				if (push) begin
					tail_q <= wrap_next(tail_q);
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			status         <= status_n;
			new_index      <= nidx_n;
			new_generation <= ngen_n;
			alive_flag     <= alive_n;
			location_out   <= lo_n;
			signature_out  <= so_n;
			live_count     <= live_n;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("free list fill above slot count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.go && pop) |-> (fill_q != '0))
		else $error("pop from empty free list");

	a_write_only_when_sequenced: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_we || sig_we || loc_we || fifo_we) |-> (cmd.clear || cmd.go))
		else $error("memory write outside clear or commit");

endmodule

// ===== hdl/generational_handle_allocator_core.sv =====
// Generational handle allocator: free-index FIFO plus per-slot generation, signature and
// location memories. After reset a clearing sweep over all SLOT_COUNT slots runs with s_tready
// low; it zeroes the slot memories and loads the free list with 0..SLOT_COUNT-1. Then each
// operation is accepted, then committed: the accept cycle reads the slot memories (a create addresses
// them with the prefetched free-list head), the commit updates memories and counters and
// loads the result register. The item rate is set by that read then write on the slot memory
// ports; a result not yet taken holds the commit cycle until m_tready frees the register.
// Depends on gha_pkg, gha_ctrl and gha_datapath.
module generational_handle_allocator_core
	import gha_pkg::*;
#(
	parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
	parameter int SIGNATURE_BITS = SIG_BITS_DEF,
	parameter int LOCATION_BITS  = LOC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// handle_index, handle_generation, signature_in, location_in
	input  logic [S_TDATA_W-1:0] s_tdata,
	// opcode
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// new_index, new_generation, alive_flag, location_out, signature_out, live_count, zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// status
	output logic [STATUS_W-1:0]  m_tuser
);

	gha_cmd_t cmd;
	gha_sts_t sts;

	logic [FIELD_W-1:0] new_index, new_generation, location_out, signature_out;
	logic               alive_flag;
	logic [LIVE_W-1:0]  live_count;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gha_datapath #(
		.SLOT_COUNT     (SLOT_COUNT),
		.SIGNATURE_BITS (SIGNATURE_BITS),
		.LOCATION_BITS  (LOCATION_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.opcode            (s_tuser),
		.handle_index      (s_tdata[31:0]),
		.handle_generation (s_tdata[63:32]),
		.signature_in      (s_tdata[95:64]),
		.location_in       (s_tdata[127:96]),
		.status            (m_tuser),
		.new_index         (new_index),
		.new_generation    (new_generation),
		.alive_flag        (alive_flag),
		.location_out      (location_out),
		.signature_out     (signature_out),
		.live_count        (live_count)
	);

	assign m_tdata = {4'd0, live_count, signature_out, location_out, alive_flag,
		new_generation, new_index};

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for generational_handle_allocator_core: random and directed handle ops
// are streamed in, results are checked against an in-bench slot map with free-index FIFO.
// Depends on gha_pkg and the allocator RTL.
module tb_top;
	import gha_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS = SLOT_COUNT_DEF;
	localparam int IDX_W = $clog2(NSLOTS);
	localparam logic [OP_W-1:0] OP_UNUSED_MAX = 3'd7;
	localparam int STALL_LIMIT = 8000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		bit [OP_W-1:0] opcode;
		bit [31:0] idx;
		bit [31:0] gen;
		bit [31:0] sig;
		bit [31:0] loc;
	} slot_op_t;

	typedef struct {
		bit [STATUS_W-1:0] status;
		bit [31:0] new_index;
		bit [31:0] new_gen;
		bit alive;
		bit [31:0] loc;
		bit [31:0] sig;
		bit [LIVE_W-1:0] live;
	} slot_reply_t;

	typedef struct {
		bit [31:0] idx;
		bit [31:0] gen;
	} handle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	generational_handle_allocator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// slot map shadow
	bit [IDX_W-1:0] free_list [NSLOTS];
	bit [IDX_W-1:0] free_head;
	bit [IDX_W-1:0] free_tail;
	int unsigned free_count;
	bit [31:0] gen_mem [NSLOTS];
	bit [31:0] sig_mem [NSLOTS];
	bit [31:0] loc_mem [NSLOTS];
	bit [LIVE_W-1:0] live_total;

	slot_op_t op_queue[$];
	slot_reply_t expected_replies[$];
	handle_t live_handles[$];

	bit calm = 1'b0;
	int unsigned s_idle_pct = 0;
	int unsigned m_idle_pct = 0;
	int unsigned s_gap = 0;
	int unsigned m_gap = 0;
	bit s_took = 1'b0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned strays = 0;
	int unsigned reply_count = 0;

	function automatic bit [IDX_W-1:0] ring_next(input bit [IDX_W-1:0] p);
		return (p == NSLOTS - 1) ? '0 : p + 1'b1;
	endfunction

	function automatic void forget_slot(input bit [31:0] idx);
		handle_t kept[$];
		foreach (live_handles[i])
			if (live_handles[i].idx != idx)
				kept.push_back(live_handles[i]);
		live_handles = kept;
	endfunction

	function automatic slot_reply_t alloc_step(input slot_op_t op);
		slot_reply_t r;
		bit invalid;
		bit in_range;
		bit [IDX_W-1:0] s;
		handle_t h;
		r = '{default: '0};
		r.status = STS_BAD;
		invalid = (op.idx == ALL_ONES) && (op.gen == ALL_ONES);
		in_range = op.idx < NSLOTS;
		s = op.idx[IDX_W-1:0];
		case (op.opcode)
			OP_CREATE: begin
				if (free_count == 0) begin
					r.status = STS_FULL;
					r.new_index = ALL_ONES;
					r.new_gen = ALL_ONES;
				end else begin
					s = free_list[free_head];
					free_head = ring_next(free_head);
					free_count--;
					sig_mem[s] = op.sig;
					live_total = live_total + 1'b1;
					r.status = STS_DONE;
					r.new_index = 32'(s);
					r.new_gen = gen_mem[s];
					h.idx = 32'(s);
					h.gen = gen_mem[s];
					live_handles.push_back(h);
				end
			end
			OP_DESTROY: begin
				if (!invalid && in_range && gen_mem[s] == op.gen) begin
					sig_mem[s] = '0;
					loc_mem[s] = '0;
					gen_mem[s] = gen_mem[s] + 32'd1;
					// a free slot may be destroyed again; the list never overflows
					if (free_count < NSLOTS) begin
						free_list[free_tail] = s;
						free_tail = ring_next(free_tail);
						free_count++;
					end
					if (live_total > 0)
						live_total = live_total - 1'b1;
					r.status = STS_DONE;
					forget_slot(op.idx);
				end
			end
			OP_SET_LOC: begin
				if (in_range) begin
					loc_mem[s] = op.loc;
					r.status = STS_DONE;
				end
			end
			OP_SET_SIG: begin
				if (in_range) begin
					sig_mem[s] = op.sig;
					r.status = STS_DONE;
				end
			end
			OP_QUERY: begin
				if (!invalid && in_range) begin
					r.loc = loc_mem[s];
					r.sig = sig_mem[s];
					r.alive = (gen_mem[s] == op.gen) && (loc_mem[s] != 0);
					r.status = (gen_mem[s] == op.gen) ? STS_DONE : STS_BAD;
				end
			end
			default: ;
		endcase
		r.live = live_total;
		return r;
	endfunction

	function automatic void check_field(input string name, input bit [31:0] want,
		input bit [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t reply %0d: %s expected %h, got %h", $realtime, reply_count,
					name, want, got);
		end
	endfunction

	// prediction on input transfers, checking on output transfers, watchdog
	always @(posedge clk) begin
		slot_op_t op;
		slot_reply_t want;
		s_took <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			op.idx = s_tdata[31:0];
			op.gen = s_tdata[63:32];
			op.sig = s_tdata[95:64];
			op.loc = s_tdata[127:96];
			op.opcode = s_tuser;
			expected_replies.push_back(alloc_step(op));
		end
		if (arst_n && m_tvalid && m_tready) begin
			reply_count++;
			if (expected_replies.size() == 0) begin
				strays++;
				if (strays <= MAX_REPORTS)
					$display("%0t reply %0d with nothing pending", $realtime, reply_count);
			end else begin
				want = expected_replies.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("new_index", want.new_index, m_tdata[31:0]);
				check_field("new_generation", want.new_gen, m_tdata[63:32]);
				check_field("alive_flag", 32'(want.alive), 32'(m_tdata[64]));
				check_field("location_out", want.loc, m_tdata[96:65]);
				check_field("signature_out", want.sig, m_tdata[128:97]);
				check_field("live_count", 32'(want.live), 32'(m_tdata[139:129]));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t watchdog: no transfer for %0d cycles", $realtime, stall_cycles);
			$display("TB_ERROR");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// input side driver
	always @(negedge clk) begin
		slot_op_t op;
		if (arst_n && (!s_tvalid || s_took)) begin
			if (s_gap > 0) begin
				s_gap <= s_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < s_idle_pct) begin
				s_gap <= $urandom_range(0, 13);
				s_tvalid <= 1'b0;
			end else if (op_queue.size() > 0) begin
				op = op_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {op.loc, op.sig, op.gen, op.idx};
				s_tuser <= op.opcode;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// output side back-pressure
	always @(negedge clk) begin
		if (m_gap > 0) begin
			m_gap <= m_gap - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < m_idle_pct) begin
			m_gap <= $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	task automatic push_op(input bit [OP_W-1:0] opcode, input bit [31:0] idx,
		input bit [31:0] gen, input bit [31:0] sig, input bit [31:0] loc);
		slot_op_t op;
		op.opcode = opcode;
		op.idx = idx;
		op.gen = gen;
		op.sig = sig;
		op.loc = loc;
		op_queue.push_back(op);
	endtask

	task automatic drain_inputs();
		while (op_queue.size() > 0 || s_tvalid)
			@(posedge clk);
	endtask

	function automatic bit [31:0] pick_index();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return NSLOTS;
			2: return ALL_ONES;
			default: return $urandom_range(0, NSLOTS - 1);
		endcase
	endfunction

	// one random op: mostly well-formed use of live handles, some noise
	task automatic push_random_op();
		handle_t h;
		int unsigned r;
		bit [31:0] loc;
		r = $urandom_range(0, 99);
		if (live_handles.size() == 0 && r >= 25 && r < 90)
			r = 0;
		if (live_handles.size() > 0)
			h = live_handles[$urandom_range(0, live_handles.size() - 1)];
		loc = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
		if (r < 25)
			push_op(OP_CREATE, $urandom, $urandom, $urandom, $urandom);
		else if (r < 40)
			push_op(OP_DESTROY, h.idx, h.gen, $urandom, $urandom);
		else if (r < 55)
			push_op(OP_SET_LOC, h.idx, $urandom, $urandom, loc);
		else if (r < 65)
			push_op(OP_SET_SIG, h.idx, $urandom, $urandom, $urandom);
		else if (r < 90)
			push_op(OP_QUERY, h.idx, h.gen, $urandom, $urandom);
		else if (r < 93)
			push_op(OP_W'($urandom_range(OP_DESTROY, OP_QUERY)), ALL_ONES, ALL_ONES,
				$urandom, loc);
		else if (r < 96 && live_handles.size() > 0)
			push_op(OP_W'($urandom_range(OP_DESTROY, OP_QUERY)), h.idx,
				h.gen + $urandom_range(1, 3), $urandom, loc);
		else
			push_op(OP_W'($urandom_range(0, OP_UNUSED_MAX)), pick_index(), $urandom,
				$urandom, loc);
	endtask

	initial begin
		for (int i = 0; i < NSLOTS; i++) begin
			free_list[i] = IDX_W'(i);
			gen_mem[i] = '0;
			sig_mem[i] = '0;
			loc_mem[i] = '0;
		end
		free_head = '0;
		free_tail = '0;
		free_count = NSLOTS;
		live_total = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: free-slot destroy with full list, then handle life cycle and corners
		push_op(OP_DESTROY, 32'd5, 32'd0, $urandom, $urandom);
		push_op(OP_CREATE, $urandom, $urandom, ALL_ONES, $urandom);
		push_op(OP_CREATE, $urandom, $urandom, 32'd0, $urandom);
		push_op(OP_QUERY, 32'd0, 32'd0, $urandom, $urandom);
		push_op(OP_SET_LOC, 32'd0, $urandom, $urandom, ALL_ONES);
		push_op(OP_SET_LOC, NSLOTS - 1, ALL_ONES, $urandom, 32'd1);
		push_op(OP_SET_LOC, NSLOTS, 32'd0, $urandom, $urandom);
		push_op(OP_SET_LOC, ALL_ONES, 32'd0, $urandom, $urandom);
		push_op(OP_SET_SIG, 32'd1, ALL_ONES, 32'hA5A5_A5A5, $urandom);
		push_op(OP_SET_SIG, NSLOTS, 32'd0, $urandom, $urandom);
		push_op(OP_QUERY, 32'd0, 32'd0, $urandom, $urandom);
		push_op(OP_QUERY, 32'd0, 32'd7, $urandom, $urandom);
		push_op(OP_QUERY, ALL_ONES, ALL_ONES, $urandom, $urandom);
		push_op(OP_QUERY, NSLOTS, 32'd0, $urandom, $urandom);
		push_op(OP_QUERY, ALL_ONES, 32'd3, $urandom, $urandom);
		push_op(OP_DESTROY, ALL_ONES, ALL_ONES, $urandom, $urandom);
		push_op(OP_DESTROY, 32'd2000, 32'd0, $urandom, $urandom);
		push_op(OP_DESTROY, ALL_ONES, 32'd0, $urandom, $urandom);
		push_op(OP_DESTROY, 32'd0, 32'd1, $urandom, $urandom);
		push_op(OP_DESTROY, 32'd0, 32'd0, $urandom, $urandom);
		push_op(OP_DESTROY, 32'd0, 32'd0, $urandom, $urandom);
		push_op(OP_QUERY, 32'd0, 32'd1, $urandom, $urandom);
		// free slot destroyed while the list has room: index goes in twice
		push_op(OP_DESTROY, 32'd300, 32'd0, $urandom, $urandom);
		push_op(OP_QUERY, NSLOTS - 1, 32'd0, $urandom, $urandom);
		for (int op = OP_QUERY + 1; op <= OP_UNUSED_MAX; op++)
			push_op(OP_W'(op), $urandom_range(0, NSLOTS - 1), 32'd0, $urandom, $urandom);
		drain_inputs();

		for (int i = 0; i < 330; i++) begin
			if (i % 40 == 0) begin
				s_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
				m_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
			end
			// keep the live-handle pool close to the accepted stream
			while (op_queue.size() >= 2)
				@(posedge clk);
			push_random_op();
		end

		drain_inputs();
		calm = 1'b1;
		for (int i = 0; i < 40; i++) begin
			while (op_queue.size() >= 2)
				@(posedge clk);
			push_random_op();
		end

		drain_inputs();
		while (expected_replies.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && strays == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
